### hdl/ocl_pkg.sv
// Package with the item types, widths, status codes and sequencer states of the chord fit block.
package ocl_pkg;

  // Default capacity of the point store.
  localparam int OCL_MAX_POINTS = 32;

  // Width of the signed dividend dy*x; the product of a 17-bit and a 16-bit value.
  localparam int DIV_W = 33;
  // Width of the chord values, offsets and the unsaturated result.
  localparam int VAL_W = 40;

  localparam logic signed [VAL_W-1:0] SAT_MAX = VAL_W'(64'sd2147483647);
  localparam logic signed [VAL_W-1:0] SAT_MIN = -VAL_W'(64'sd2147483648);

  // Status codes of a result item.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FEW       = 2'd1;
  localparam logic [1:0] STATUS_EQUAL_X   = 2'd2;
  localparam logic [1:0] STATUS_DROPPED   = 2'd3;

  // Action codes of an input item.
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic               lower_mode;
  } item_t;

  typedef struct packed {
    logic signed [31:0] line_y;
    logic [1:0]         status;
  } result_t;

  // Sequencer states of a query.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVGO,
    S_DIVW,
    S_RD,
    S_RDW,
    S_DONE
  } state_t;

  // What the current division is for.
  typedef enum logic [1:0] {
    PH_BASE,
    PH_POINT,
    PH_FINAL
  } phase_t;

endpackage

### hdl/ocl_ram.sv
// Generic single-port-write, registered-read RAM.
module ocl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/ocl_div.sv
// Iterative signed-by-positive divider, one quotient bit per cycle, truncating toward zero.
module ocl_div
  import ocl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend,
  input  logic [15:0]             divisor,
  output logic                    done,
  output logic signed [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic [DIV_W-1:0]   quo;
  logic [16:0]        rem;
  logic [15:0]        dvs;
  logic [16:0]        rem_sh;

  // Shift in the next dividend bit and try a subtraction.
  assign rem_sh = {rem[15:0], quo[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
        neg  <= dividend[DIV_W-1];
        quo  <= dividend[DIV_W-1] ? -dividend : dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= rem_sh - {1'b0, dvs};
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restore the sign of the magnitude quotient.
  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

### hdl/offset_chord_line_fit.sv
// Top level of the offset chord line fit block: point store, sequencer and result register.
//
// Items arrive on item/item_valid/item_stall; an item is taken when item_valid is high
// and item_stall is low. An append item writes one point, unless the store is full, and
// gives no result. A query item makes the block walk the stored points: each point other
// than the chord ends costs one memory read plus one multiply and one division in the
// serial divider. While a query runs item_stall is high. The result leaves on
// result/result_valid/result_stall from an output register; it holds steady while
// result_stall is high, and appends are taken meanwhile. A finished query waits for the
// register to free before it writes it and clears the point store. Reset (rst,
// synchronous, active high) empties the store, drops any pending result and returns the
// sequencer to idle; the store memory itself is not cleared and needs no pass.
module offset_chord_line_fit
  import ocl_pkg::*;
#(
  parameter int MAX_POINTS = OCL_MAX_POINTS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;
  phase_t phase;

  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [AW-1:0]     left_idx, right_idx;
  logic              overflowed;
  logic signed [15:0] ax, ay, bx, by;
  logic signed [15:0] qx;
  logic              lower;
  logic signed [15:0] x_sel, y_pt;
  logic signed [DIV_W-1:0] prod;
  logic signed [VAL_W-1:0] c0, offset, res;
  logic [1:0]        stat;

  logic              ram_we;
  logic [31:0]       ram_rdata;
  logic              div_start, div_done;
  logic signed [DIV_W-1:0] quo;

  logic              accept, full;
  logic              result_load;
  logic signed [16:0] dy;
  logic [15:0]       dx;
  logic signed [VAL_W-1:0] lv, gap, fin, sat;

  assign accept = item_valid && !item_stall;
  assign full   = (count == CW'(MAX_POINTS));
  assign ram_we = accept && item.action == ACT_APPEND && !full;
  assign dy     = 17'(by) - 17'(ay);
  assign dx     = 16'(bx - ax);
  assign result_load = (state == S_DONE) && (!result_valid || !result_stall);

  ocl_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({item.coord_x, item.coord_y}),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  ocl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (dx),
    .done     (div_done),
    .quotient (quo)
  );

  // Chord value, distance from the point, final offset value and saturation.
  assign lv   = VAL_W'(quo) + c0;
  assign gap  = lower ? (lv - VAL_W'(y_pt)) : (VAL_W'(y_pt) - lv);
  assign fin  = lower ? (lv - offset) : (lv + offset);
  assign sat  = (fin > SAT_MAX) ? SAT_MAX : ((fin < SAT_MIN) ? SAT_MIN : fin);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid && item.action == ACT_QUERY) begin
          if (count < CW'(2) || bx == ax) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL:   state_next = S_DIVGO;
      S_DIVGO: begin
        div_start  = 1'b1;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          state_next = (phase == PH_FINAL) ? S_DONE : S_RD;
        end
      end
      S_RD:    state_next = (idx == count) ? S_MUL : S_RDW;
      S_RDW: begin
        if (idx[AW-1:0] == left_idx || idx[AW-1:0] == right_idx) begin
          state_next = S_RD;
        end else begin
          state_next = S_MUL;
        end
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Point bookkeeping and query datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      left_idx     <= '0;
      right_idx    <= '0;
      overflowed   <= 1'b0;
      result_valid <= 1'b0;
      idx          <= '0;
      phase        <= PH_BASE;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && item.action == ACT_APPEND) begin
            if (full) begin
              overflowed <= 1'b1;
            end else begin
              if (count == '0) begin
                left_idx  <= '0;
                right_idx <= '0;
                ax <= item.coord_x;
                ay <= item.coord_y;
                bx <= item.coord_x;
                by <= item.coord_y;
              end else begin
                if (item.coord_x < ax) begin
                  left_idx <= count[AW-1:0];
                  ax <= item.coord_x;
                  ay <= item.coord_y;
                end
                if (item.coord_x >= bx) begin
                  right_idx <= count[AW-1:0];
                  bx <= item.coord_x;
                  by <= item.coord_y;
                end
              end
              count <= count + 1'b1;
            end
          end else if (accept) begin
            qx     <= item.coord_x;
            lower  <= item.lower_mode;
            offset <= '0;
            res    <= '0;
            x_sel  <= ax;
            phase  <= PH_BASE;
            idx    <= '0;
            if (count < CW'(2)) begin
              stat <= STATUS_FEW;
            end else if (bx == ax) begin
              stat <= STATUS_EQUAL_X;
            end else begin
              stat <= overflowed ? STATUS_DROPPED : STATUS_OK;
            end
          end
        end
        S_MUL: begin
          prod <= DIV_W'(dy) * DIV_W'(x_sel);
        end
        S_DIVW: begin
          if (div_done) begin
            unique case (phase)
              PH_BASE:  c0 <= VAL_W'(ay) - VAL_W'(quo);
              PH_POINT: begin
                if (gap > offset) begin
                  offset <= gap;
                end
                idx <= idx + 1'b1;
              end
              PH_FINAL: res <= sat;
              default:  res <= sat;
            endcase
          end
        end
        S_RD: begin
          if (idx == count) begin
            x_sel <= qx;
            phase <= PH_FINAL;
          end
        end
        S_RDW: begin
          if (idx[AW-1:0] == left_idx || idx[AW-1:0] == right_idx) begin
            idx <= idx + 1'b1;
          end else begin
            x_sel <= $signed(ram_rdata[31:16]);
            y_pt  <= $signed(ram_rdata[15:0]);
            phase <= PH_POINT;
          end
        end
        S_DONE: begin
          if (result_load) begin
            result.line_y <= 32'(res);
            result.status <= stat;
            count         <= '0;
            left_idx      <= '0;
            right_idx     <= '0;
            overflowed    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count above capacity");

  a_chord_order: assert property (@(posedge clk) disable iff (rst)
    (count != '0 && state == S_IDLE) |-> ax <= bx)
    else $error("left point lies right of right point");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_QUERY) |=> state != S_IDLE)
    else $error("query accepted without starting work");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result appeared outside the done state");

  a_ends_valid: assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> (CW'(left_idx) < count && CW'(right_idx) < count))
    else $error("chord end index beyond stored points");
`endif

endmodule
